// ===== rtl/core/pes_pkg.sv =====
// Package for the payload experiment sequencer: types, register codes, constants.
`timescale 1ns / 1ps
package pes_pkg;

   localparam int unsigned CHUNK_BYTES_DEF = 256;
   localparam logic [15:0] SecondsPerMinute = 16'd60;
   localparam logic [1:0]  SupplyFull = 2'd0;

   typedef enum logic [2:0] {
      CSR_MIN_MINUTES     = 3'd0,
      CSR_MAX_MINUTES     = 3'd1,
      CSR_DEFAULT_MINUTES = 3'd2,
      CSR_FPGA_ON_DELAY   = 3'd3,
      CSR_TEMP_LOW_LIMIT  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [7:0]         min_minutes;
      logic [7:0]         max_minutes;
      logic [7:0]         default_minutes;
      logic [15:0]        fpga_on_delay;
      logic signed [15:0] temp_low_limit;
   } cfg_type;

   typedef struct packed {
      logic               cmd_valid;
      logic [7:0]         cmd_minutes;
      logic [1:0]         supply_level;
      logic signed [15:0] core_temp;
      logic [31:0]        write_address;
   } req_item_type;

   typedef struct packed {
      logic        board_power;
      logic        fpga_power;
      logic        start_pulse;
      logic        read_valid;
      logic [31:0] read_address;
      logic [8:0]  read_length;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] countdown;
      logic [15:0] duration;
      logic        board_on;
      logic        fpga_on;
      logic        fpga_armed;
      logic        base_known;
      logic [31:0] read_pointer;
      logic        pending_valid;
      logic [7:0]  pending_minutes;
   } seq_state_type;

endpackage

// ===== rtl/core/pes_csr.sv =====
// Configuration registers of the payload experiment sequencer.
`timescale 1ns / 1ps
module pes_csr
   import pes_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_MIN_MINUTES:     cfg_in.min_minutes     = csr_data[7:0];
            CSR_MAX_MINUTES:     cfg_in.max_minutes     = csr_data[7:0];
            CSR_DEFAULT_MINUTES: cfg_in.default_minutes = csr_data[7:0];
            CSR_FPGA_ON_DELAY:   cfg_in.fpga_on_delay   = csr_data;
            CSR_TEMP_LOW_LIMIT:  cfg_in.temp_low_limit  = $signed(csr_data);
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_minutes     <= 8'd1;
         cfg_ff.max_minutes     <= 8'd60;
         cfg_ff.default_minutes <= 8'd10;
         cfg_ff.fpga_on_delay   <= 16'd5;
         cfg_ff.temp_low_limit  <= 16'sd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/pes_step.sv =====
// One-tick update of the sequencer: next state and result from state, item and config.
`timescale 1ns / 1ps
module pes_step
   import pes_pkg::*;
#(
   parameter int unsigned CHUNK_BYTES = CHUNK_BYTES_DEF
) (
   input  cfg_type       cfg,
   input  seq_state_type state_cur,
   input  req_item_type  item,
   output seq_state_type state_nxt,
   output rsp_item_type  result
);

   localparam int unsigned LenW = $clog2(CHUNK_BYTES + 1);

   seq_state_type n;
   logic          temp_ok;
   logic [15:0]   minutes16;
   logic [15:0]   on_mark;
   logic [31:0]   diff;
   logic [LenW-1:0] len;
   logic          start;
   logic          rd;
   logic [31:0]   rd_addr;
   logic [LenW-1:0] rd_len;

   assign temp_ok = item.core_temp < cfg.temp_low_limit;
   assign on_mark = state_cur.duration - cfg.fpga_on_delay;

   always_comb begin
      n         = state_cur;
      start     = 1'b0;
      rd        = 1'b0;
      rd_addr   = '0;
      rd_len    = '0;
      minutes16 = '0;
      diff      = '0;
      len       = '0;

      if (item.cmd_valid) begin
         n.pending_valid   = 1'b1;
         n.pending_minutes = item.cmd_minutes;
      end

      if (state_cur.countdown == 16'd0) begin
         if (n.pending_valid) begin
            n.pending_valid = 1'b0;
            if (n.pending_minutes >= cfg.min_minutes && n.pending_minutes <= cfg.max_minutes)
               minutes16 = {8'd0, n.pending_minutes};
            else
               minutes16 = {8'd0, cfg.default_minutes};
            if (n.pending_minutes == 8'd0)
               n.countdown = '0;
            else
               n.countdown = 16'(minutes16 * SecondsPerMinute);
            n.duration = n.countdown;
         end
      end else begin
         n.countdown = state_cur.countdown - 16'd1;
         if (state_cur.board_on) begin
            // stop command while running
            if (n.pending_valid && n.pending_minutes == 8'd0) begin
               n.pending_valid = 1'b0;
               n.countdown     = '0;
               n.fpga_armed    = 1'b0;
            end
            if (state_cur.base_known) begin
               if (n.fpga_armed && temp_ok) begin
                  if (n.countdown == on_mark) begin
                     n.fpga_on = 1'b1;
                     start     = 1'b1;
                  end
                  if (n.countdown == 16'd0) begin
                     n.fpga_on    = 1'b0;
                     n.fpga_armed = 1'b0;
                  end
               end else begin
                  n.fpga_on    = 1'b0;
                  n.fpga_armed = 1'b0;
                  n.countdown  = '0;
               end
            end else begin
               n.read_pointer = item.write_address;
               n.base_known   = 1'b1;
            end

            if (item.write_address <= n.read_pointer) begin
               n.read_pointer = item.write_address;
               if (n.countdown == 16'd0) begin
                  n.fpga_on    = 1'b0;
                  n.fpga_armed = 1'b0;
                  n.board_on   = 1'b0;
               end
            end else begin
               diff = item.write_address - n.read_pointer;
               if (diff >= 32'(CHUNK_BYTES))
                  len = LenW'(CHUNK_BYTES);
               else
                  len = diff[LenW-1:0];
               rd             = 1'b1;
               rd_addr        = n.read_pointer;
               rd_len         = len;
               n.read_pointer = n.read_pointer + 32'(len);
            end
         end
      end

      if (item.supply_level == SupplyFull) begin
         if (n.countdown != 16'd0) begin
            n.board_on = 1'b1;
            if (!n.fpga_armed && temp_ok)
               n.fpga_armed = 1'b1;
         end
      end else if (n.board_on) begin
         n.countdown     = '0;
         n.fpga_on       = 1'b0;
         n.board_on      = 1'b0;
         n.fpga_armed    = 1'b0;
         n.pending_valid = 1'b0;
      end
   end

   assign state_nxt = n;

   always_comb begin
      result.board_power  = n.board_on;
      result.fpga_power   = n.fpga_on;
      result.start_pulse  = start;
      result.read_valid   = rd;
      result.read_address = rd_addr;
      result.read_length  = 9'(rd_len);
   end

endmodule

// ===== rtl/core/payload_experiment_sequencer.sv =====
// Top level of the payload experiment sequencer.
// The request is held in an input register, then its result in a result register; a response stall can hold it between.
// Throughput: one tick per cycle while the response side does not stall; the state update is combinational.
// Reset (synchronous): state cleared, both channels empty, registers to their reset values.
`timescale 1ns / 1ps
module payload_experiment_sequencer
   import pes_pkg::*;
#(
   parameter int unsigned CHUNK_BYTES = CHUNK_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd_valid,
   input  logic [7:0]         req_cmd_minutes,
   input  logic [1:0]         req_supply_level,
   input  logic signed [15:0] req_core_temp,
   input  logic [31:0]        req_write_address,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_board_power,
   output logic               rsp_fpga_power,
   output logic               rsp_start_pulse,
   output logic               rsp_read_valid,
   output logic [31:0]        rsp_read_address,
   output logic [8:0]         rsp_read_length
);

   cfg_type       cfg;
   logic          s1_valid_ff;
   req_item_type  s1_item_ff;
   seq_state_type state_ff;
   seq_state_type state_in;
   rsp_item_type  result;
   logic          rsp_valid_ff;
   rsp_item_type  rsp_item_ff;
   logic          step_fire;
   logic          req_take;

   pes_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pes_step #(
      .CHUNK_BYTES (CHUNK_BYTES)
   ) u_step (
      .cfg       (cfg),
      .state_cur (state_ff),
      .item      (s1_item_ff),
      .state_nxt (state_in),
      .result    (result)
   );

   // item in stage 1 moves on when the result register is free or being drained
   assign step_fire = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (step_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff.cmd_valid     <= req_cmd_valid;
         s1_item_ff.cmd_minutes   <= req_cmd_minutes;
         s1_item_ff.supply_level  <= req_supply_level;
         s1_item_ff.core_temp     <= req_core_temp;
         s1_item_ff.write_address <= req_write_address;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (step_fire) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_board_power  = rsp_item_ff.board_power;
   assign rsp_fpga_power   = rsp_item_ff.fpga_power;
   assign rsp_start_pulse  = rsp_item_ff.start_pulse;
   assign rsp_read_valid   = rsp_item_ff.read_valid;
   assign rsp_read_address = rsp_item_ff.read_address;
   assign rsp_read_length  = rsp_item_ff.read_length;

   // FPGA supply never on without board supply
   a_fpga_needs_board: assert property (@(posedge clock) disable iff (reset)
      !state_ff.board_on |-> !state_ff.fpga_on)
      else $error("fpga on while board off");

   // a reduced energy level leaves the board off
   a_low_energy_off: assert property (@(posedge clock) disable iff (reset)
      (step_fire && s1_item_ff.supply_level != SupplyFull) |=> !state_ff.board_on)
      else $error("board on after low energy tick");

   // backpressure only when both stages are full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("stall with a free stage");

   // a response without a read request carries a zero address and length
   a_no_read_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_read_valid) |-> (rsp_read_address == 32'd0 && rsp_read_length == 9'd0))
      else $error("idle read fields not zero");

endmodule
